// File: rtl/srqs_pkg.sv
// shared constants, types and helper functions for the sensor request queue sequencer
package srqs_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int SENSOR_COUNT = 16;

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int SENSOR_W = 4;
  localparam int MAP_W    = 16;
  localparam int ACTION_W = 2;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_RECV = 2'd2
  } action_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    logic    set_rx;
    logic    finish;
    logic    active;
    logic    rejected;
    logic    done;
    action_t action;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ring_full;
    logic ring_empty;
    logic need_next;
    logic rx_phase;
    logic sends_first;
  } dp_status_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // sensors past the populated range are receive only
  function automatic logic kind_bit(input logic [MAP_W-1:0] map,
                                    input logic [SENSOR_W-1:0] s);
    logic r;
    if (int'(s) >= SENSOR_COUNT) begin
      r = 1'b0;
    end else begin
      r = map[s];
    end
    return r;
  endfunction

endpackage

// File: rtl/srqs_if.sv
// handshake channel interfaces: input items, results and register writes
interface srqs_item_if;
  import srqs_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SENSOR_W-1:0] sensor_index;
  logic                bus_refused;
  modport source (output valid, mode, sensor_index, bus_refused, input ready);
  modport sink (input valid, mode, sensor_index, bus_refused, output ready);
endinterface

interface srqs_result_if;
  import srqs_pkg::*;
  logic                valid;
  logic                ready;
  logic                enqueue_rejected;
  logic [ACTION_W-1:0] action;
  logic [SENSOR_W-1:0] target_sensor;
  logic                request_done;
  modport source (output valid, enqueue_rejected, action, target_sensor, request_done,
                  input ready);
  modport sink (input valid, enqueue_rejected, action, target_sensor, request_done,
                output ready);
endinterface

interface srqs_cfg_if;
  import srqs_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/srqs_ctrl.sv
// controller: output register occupancy and per-item step decisions
module srqs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   mode,
  input  logic                   bus_refused,
  output logic                   result_valid,
  input  logic                   result_ready,
  input  srqs_pkg::dp_status_t   status,
  output srqs_pkg::dp_cmd_t      cmd
);
  import srqs_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   step;
  logic   send_now;

  assign item_ready   = (state == ST_EMPTY) || result_ready;
  assign result_valid = (state == ST_FULL);
  assign step         = item_valid && item_ready;
  assign send_now     = status.sends_first && !status.rx_phase;

  always_comb begin
    cmd          = '0;
    cmd.action   = ACT_NONE;
    cmd.load     = step;
    if (step) begin
      if (mode == MODE_ENQUEUE) begin
        cmd.rejected = status.ring_full;
        cmd.push     = !status.ring_full;
      end else if (!(status.need_next && status.ring_empty)) begin
        cmd.active = 1'b1;
        cmd.pop    = status.need_next;
        if (send_now) begin
          cmd.action = ACT_SEND;
          cmd.set_rx = !bus_refused;
        end else begin
          cmd.action = ACT_RECV;
          cmd.finish = !bus_refused;
          cmd.done   = !bus_refused;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: if (step) state_next = ST_FULL;
      ST_FULL:  if (result_ready && !step) state_next = ST_EMPTY;
      default:  state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/srqs_datapath.sv
// datapath: request ring, pointers, request progress, sensor kind map, result register
module srqs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [srqs_pkg::SENSOR_W-1:0]   sensor_index,
  input  logic                            cfg_we,
  input  logic [srqs_pkg::MAP_W-1:0]      cfg_data,
  input  srqs_pkg::dp_cmd_t               cmd,
  output srqs_pkg::dp_status_t            status,
  output logic                            enqueue_rejected,
  output logic [srqs_pkg::ACTION_W-1:0]   action,
  output logic [srqs_pkg::SENSOR_W-1:0]   target_sensor,
  output logic                            request_done
);
  import srqs_pkg::*;

  logic [SENSOR_W-1:0] ring [QUEUE_DEPTH];
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic                need_next;
  logic                rx_phase;
  logic [SENSOR_W-1:0] cur_sensor;
  logic [MAP_W-1:0]    kind_map;
  logic [SENSOR_W-1:0] sensor_sel;

  // a pop takes the head entry, otherwise the request in progress
  assign sensor_sel = need_next ? ring[rd_ptr] : cur_sensor;

  assign status.ring_full   = (ptr_next(wr_ptr) == rd_ptr);
  assign status.ring_empty  = (rd_ptr == wr_ptr);
  assign status.need_next   = need_next;
  assign status.rx_phase    = rx_phase;
  assign status.sends_first = kind_bit(kind_map, sensor_sel);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring[wr_ptr] <= sensor_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      need_next  <= 1'b1;
      rx_phase   <= 1'b0;
      cur_sensor <= '0;
      kind_map   <= '0;
    end else begin
      if (cfg_we) begin
        kind_map <= cfg_data;
      end
      if (cmd.push) begin
        wr_ptr <= ptr_next(wr_ptr);
      end
      if (cmd.pop) begin
        rd_ptr     <= ptr_next(rd_ptr);
        cur_sensor <= ring[rd_ptr];
      end
      // a request popped and finished on the same tick still wants the next one
      if (cmd.finish) begin
        need_next <= 1'b1;
      end else if (cmd.pop) begin
        need_next <= 1'b0;
      end
      if (cmd.set_rx) begin
        rx_phase <= 1'b1;
      end else if (cmd.finish) begin
        rx_phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      enqueue_rejected <= cmd.rejected;
      action           <= cmd.action;
      target_sensor    <= cmd.active ? sensor_sel : '0;
      request_done     <= cmd.done;
    end
  end

endmodule

// File: rtl/sensor_request_queue_sequencer.sv
// top level of the sensor request queue sequencer
//
// Each accepted item is either an enqueue of a sensor index into a ring queue
// (QUEUE_DEPTH slots, one kept empty, so QUEUE_DEPTH-1 requests at most) or a
// service tick that advances the request in progress by one bus step. Every
// item gives exactly one result: a reject flag for enqueues, or the action
// tried on a tick (none, send, receive), its target sensor and a done flag
// when the final receive of a request went through. The kind register holds
// one bit per sensor (set: send then receive, clear: receive only) and is read
// anew on every tick. An item is taken every cycle while the input is ready:
// the whole decision is combinational logic, its result is loaded into the
// output register at the transfer edge and is offered from the next cycle on.
// The input is ready whenever that output register is empty or being drained
// in the same cycle, so a stalled result holds off only the next item. Register
// writes are always ready and apply to items transferred after the write edge.
module sensor_request_queue_sequencer (
  input logic         clk,
  input logic         rst,
  srqs_item_if.sink   item,
  srqs_result_if.source result,
  srqs_cfg_if.sink    cfg
);
  import srqs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes never stall
  assign cfg.ready = 1'b1;

  // handshakes and the per-item decision
  srqs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .mode         (item.mode),
    .bus_refused  (item.bus_refused),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // queue storage, request progress and the result register
  srqs_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .sensor_index     (item.sensor_index),
    .cfg_we           (cfg.valid),
    .cfg_data         (cfg.data),
    .cmd              (cmd),
    .status           (status),
    .enqueue_rejected (result.enqueue_rejected),
    .action           (result.action),
    .target_sensor    (result.target_sensor),
    .request_done     (result.request_done)
  );

endmodule
